FILE: rtl/hh4_pkg.sv
// Package for the HCI H4 packet deframer: types, codes, widths and small decode
// functions shared by the interfaces, the deframer and its checker.
// Depends on nothing.
`default_nettype none

package hh4_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int MAXL_W = 17;
  localparam int CIDX_W = 2;

  localparam logic [MAXL_W-1:0] MAX_LEN_RESET = 17'd512;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_MAX_LEN     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CLASSIC_EN  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_EXT_ADV_EN  = 2'd2;

  // Event codes and LE meta subevents that matter for discarding.
  localparam logic [7:0] EVT_INQ_RSSI    = 8'h22;
  localparam logic [7:0] EVT_EXT_INQ     = 8'h2F;
  localparam logic [7:0] EVT_LE_META     = 8'h3E;
  localparam logic [7:0] SUB_ADV_REPORT  = 8'h02;
  localparam logic [7:0] SUB_EXT_ADV     = 8'h0D;
  localparam logic [7:0] TYPE_FIRST      = 8'h01;
  localparam logic [7:0] TYPE_LAST       = 8'h05;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CMD,
    KIND_ACL,
    KIND_SCO,
    KIND_EVENT,
    KIND_ISO
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_TYPE,
    ST_OVERSIZE
  } status_t;

  function automatic logic [2:0] hdr_size(kind_t k);
    logic [2:0] s;
    unique case (k)
      KIND_ACL:   s = 3'd4;
      KIND_EVENT: s = 3'd2;
      KIND_ISO:   s = 3'd4;
      default:    s = 3'd3;
    endcase
    return s;
  endfunction

  // Payload length as carried in a complete header.
  function automatic logic [LEN_W-1:0] len_from_header(kind_t k, logic [31:0] hdr);
    logic [LEN_W-1:0] l;
    unique case (k)
      KIND_ACL:   l = hdr[31:16];
      KIND_EVENT: l = {8'd0, hdr[15:8]};
      KIND_ISO:   l = {2'b00, hdr[29:16]};
      default:    l = {8'd0, hdr[23:16]};
    endcase
    return l;
  endfunction

  // An event may be dropped: inquiry results, LE advertising reports, or an
  // extended report holding one legacy advertisement.
  function automatic logic evt_discard(logic [7:0] code, logic [31:0] peek,
                                       logic classic_en, logic ext_en);
    logic d;
    d = 1'b0;
    if (code == EVT_INQ_RSSI || code == EVT_EXT_INQ) begin
      d = classic_en;
    end else if (code == EVT_LE_META) begin
      if (peek[7:0] == SUB_ADV_REPORT) begin
        d = 1'b1;
      end else if (peek[7:0] == SUB_EXT_ADV && ext_en) begin
        d = (peek[15:8] == 8'd1) && peek[20];
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hh4_if.sv
// Handshake channels of the HCI H4 deframer: byte stream in, annotated
// results out, and the configuration write channel. Depends on hh4_pkg.
`default_nettype none

interface hh4_byte_if import hh4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, data_byte, input ready);
  modport sink   (input valid, data_byte, output ready);
  modport mon    (input valid, ready, data_byte);
endinterface

interface hh4_result_if import hh4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [2:0]        packet_kind;
  logic              first_of_packet;
  logic              last_of_packet;
  logic [1:0]        status;
  logic              discardable;
  modport source (output valid, out_byte, packet_kind, first_of_packet, last_of_packet,
                  status, discardable, input ready);
  modport sink   (input valid, out_byte, packet_kind, first_of_packet, last_of_packet,
                  status, discardable, output ready);
  modport mon    (input valid, ready, out_byte, packet_kind, first_of_packet,
                  last_of_packet, status, discardable);
endinterface

interface hh4_cfg_if import hh4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [MAXL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

`default_nettype wire

FILE: rtl/hci_h4_packet_deframer_unit.sv
// HCI H4 packet deframer top level: per-byte framing state and result register.
// Depends on hh4_pkg and the channel interfaces in hh4_if.sv.
//
// Takes one H4 transport byte per cycle and returns it registered with the
// packet kind, first and last marks, a status and, on the last byte of an event,
// a discardable flag. Every byte yields exactly one result. Result valid rises
// in the cycle after acceptance, and the sustained rate is one byte per cycle:
// the framing state and the single result register update at each acceptance,
// and a byte is taken whenever the result register is empty or being emptied in
// the same cycle. An unknown type byte is reported with status 1 and the next
// byte is treated as a type byte. Oversize (status 2) is known once the header
// is complete. Configuration writes are always taken and should be made while
// no byte is in flight.
`default_nettype none

module hci_h4_packet_deframer_unit import hh4_pkg::*; (
  input  wire            clk,
  input  wire            rst,
  hh4_cfg_if.sink        cfg,
  hh4_byte_if.sink       stream,
  hh4_result_if.source   result
);

  // Configuration.
  logic [MAXL_W-1:0] max_len;
  logic              classic_en;
  logic              ext_en;

  // Framing state.
  phase_t            phase, phase_next;
  kind_t             kind_held, kind_held_next;
  logic [2:0]        header_count, header_count_next;
  logic [31:0]       header_bytes, header_bytes_next;
  logic [LEN_W-1:0]  payload_left, payload_left_next;
  logic [2:0]        payload_index, payload_index_next;
  logic [31:0]       peek_bytes, peek_bytes_next;
  logic              oversize, oversize_next;

  // Result register.
  logic              res_valid;
  logic [BYTE_W-1:0] res_byte;
  kind_t             res_kind;
  logic              res_first;
  logic              res_last;
  status_t           res_status;
  logic              res_disc;

  // Values for the byte being accepted.
  logic              fire;
  logic [BYTE_W-1:0] b;
  logic [31:0]       hdr_merged;
  logic [31:0]       peek_merged;
  logic [31:0]       peek_view;
  logic [2:0]        cnt_inc;
  logic [2:0]        size;
  logic              hdr_done;
  logic [LEN_W-1:0]  len;
  logic [MAXL_W-1:0] total;
  logic              over_now;
  logic [LEN_W-1:0]  left_dec;
  logic              type_ok;
  logic [7:0]        evt_code;

  kind_t             o_kind;
  logic              o_first;
  logic              o_last;
  status_t           o_status;
  logic              o_disc;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !res_valid || result.ready;
  assign fire         = stream.valid && stream.ready;
  assign b            = stream.data_byte;

  assign hdr_merged  = header_bytes | (32'(b) << {header_count[1:0], 3'b000});
  assign peek_merged = payload_index[2] ? peek_bytes
                                        : (peek_bytes | (32'(b) << {payload_index[1:0], 3'b000}));
  assign peek_view   = (phase == PH_PAYLOAD) ? peek_merged : peek_bytes;
  assign cnt_inc     = header_count + 3'd1;
  assign size        = hdr_size(kind_held);
  assign hdr_done    = cnt_inc >= size;
  assign len         = len_from_header(kind_held, hdr_merged);
  assign total       = MAXL_W'(1) + MAXL_W'(size) + MAXL_W'(len);
  assign over_now    = total > max_len;
  assign left_dec    = payload_left - LEN_W'(1);
  assign type_ok     = (b >= TYPE_FIRST) && (b <= TYPE_LAST);
  assign evt_code    = (phase == PH_HEADER) ? hdr_merged[7:0] : header_bytes[7:0];

  // Next framing state for an accepted byte.
  always_comb begin
    phase_next         = phase;
    kind_held_next     = kind_held;
    header_count_next  = header_count;
    header_bytes_next  = header_bytes;
    payload_left_next  = payload_left;
    payload_index_next = payload_index;
    peek_bytes_next    = peek_bytes;
    oversize_next      = oversize;
    unique case (phase)
      PH_HEADER: begin
        header_bytes_next = hdr_merged;
        header_count_next = cnt_inc;
        if (hdr_done) begin
          oversize_next     = over_now;
          payload_left_next = len;
          phase_next        = (len == '0) ? PH_IDLE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        peek_bytes_next   = peek_merged;
        payload_left_next = left_dec;
        if (payload_index != 3'd7) begin
          payload_index_next = payload_index + 3'd1;
        end
        if (left_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (type_ok) begin
          kind_held_next     = kind_t'(b[2:0] - 3'd1);
          phase_next         = PH_HEADER;
          header_count_next  = '0;
          header_bytes_next  = '0;
          payload_left_next  = '0;
          payload_index_next = '0;
          peek_bytes_next    = '0;
          oversize_next      = 1'b0;
        end
      end
    endcase
  end

  // Annotation of the accepted byte.
  always_comb begin
    o_kind   = kind_held;
    o_first  = 1'b0;
    o_last   = 1'b0;
    o_status = ST_OK;
    unique case (phase)
      PH_HEADER: begin
        if (hdr_done) begin
          o_last   = (len == '0);
          o_status = over_now ? ST_OVERSIZE : ST_OK;
        end
      end
      PH_PAYLOAD: begin
        o_last   = (left_dec == '0);
        o_status = oversize ? ST_OVERSIZE : ST_OK;
      end
      default: begin
        o_first = 1'b1;
        if (type_ok) begin
          o_kind = kind_t'(b[2:0] - 3'd1);
        end else begin
          o_kind   = KIND_CMD;
          o_last   = 1'b1;
          o_status = ST_BAD_TYPE;
        end
      end
    endcase
    o_disc = o_last && (o_status != ST_BAD_TYPE) && (o_kind == KIND_EVENT) &&
             evt_discard(evt_code, peek_view, classic_en, ext_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len    <= MAX_LEN_RESET;
      classic_en <= 1'b0;
      ext_en     <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_MAX_LEN:    max_len    <= cfg.data;
        CFG_CLASSIC_EN: classic_en <= cfg.data[0];
        CFG_EXT_ADV_EN: ext_en     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      kind_held     <= KIND_CMD;
      header_count  <= '0;
      header_bytes  <= '0;
      payload_left  <= '0;
      payload_index <= '0;
      peek_bytes    <= '0;
      oversize      <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      kind_held     <= kind_held_next;
      header_count  <= header_count_next;
      header_bytes  <= header_bytes_next;
      payload_left  <= payload_left_next;
      payload_index <= payload_index_next;
      peek_bytes    <= peek_bytes_next;
      oversize      <= oversize_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_byte   <= b;
      res_kind   <= o_kind;
      res_first  <= o_first;
      res_last   <= o_last;
      res_status <= o_status;
      res_disc   <= o_disc;
    end
  end

  assign result.valid           = res_valid;
  assign result.out_byte        = res_byte;
  assign result.packet_kind     = res_kind;
  assign result.first_of_packet = res_first;
  assign result.last_of_packet  = res_last;
  assign result.status          = res_status;
  assign result.discardable     = res_disc;

endmodule

`default_nettype wire

FILE: rtl/hh4_checker.sv
// Port-level checks for the HCI H4 deframer and the bind that attaches them.
// Depends on hh4_pkg and the channel interfaces in hh4_if.sv.
`default_nettype none

module hh4_checker import hh4_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire              in_ready,
  input  wire [BYTE_W-1:0] in_byte,
  input  wire              res_valid,
  input  wire              res_ready,
  input  wire [BYTE_W-1:0] res_byte,
  input  wire [2:0]        res_kind,
  input  wire              res_first,
  input  wire              res_last,
  input  wire [1:0]        res_status,
  input  wire              res_disc
);

  // A waiting item keeps its byte, status and last mark until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) &&
      $stable(res_status) && $stable(res_last))
    else $error("result item changed while stalled");

  // A bad type byte is a one-byte packet with kind CMD and no discard mark.
  a_bad_type: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_BAD_TYPE |->
      res_first && res_last && res_kind == KIND_CMD && !res_disc)
    else $error("malformed unknown-type item");

  // A good type byte opens a packet: never last, never oversize.
  a_type_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_first && res_status != ST_BAD_TYPE |->
      !res_last && res_status == ST_OK && !res_disc)
    else $error("type byte item carries end-of-packet marks");

  // Only the last byte of an event can be marked discardable.
  a_discard: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_disc |-> res_last && res_kind == KIND_EVENT)
    else $error("discardable set outside the last byte of an event");

  // The byte is echoed in the cycle after it is accepted.
  a_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> res_valid && res_byte == $past(in_byte))
    else $error("accepted byte not echoed");

endmodule

bind hci_h4_packet_deframer_unit hh4_checker u_hh4_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (stream.valid),
  .in_ready   (stream.ready),
  .in_byte    (stream.data_byte),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_byte   (result.out_byte),
  .res_kind   (result.packet_kind),
  .res_first  (result.first_of_packet),
  .res_last   (result.last_of_packet),
  .res_status (result.status),
  .res_disc   (result.discardable)
);

`default_nettype wire
